>>> rtl/ghst_pkg.sv
// ----------------------------------------------------------------------------
// ghst_pkg: shared types for the generation handle slot table
// Request and response words, request codes, status codes and slot states.
// ----------------------------------------------------------------------------
package ghst_pkg;

  localparam int unsigned HANDLE_W      = 31;
  localparam int unsigned SLOT_IDX_W    = 10;
  localparam int unsigned CPU_ID_W      = 3;
  localparam int unsigned RUN_CNT_W     = 32;

  localparam int unsigned SLOTS_DEF     = 1024;
  localparam int unsigned CPUS_DEF      = 8;
  localparam int unsigned GEN_SHIFT_DEF = 12;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_LOOKUP  = 2'd1,
    REQ_DESTROY = 2'd2,
    REQ_RUN     = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_FREE    = 2'd1,
    STATUS_BAD_HANDLE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_RUNNABLE = 2'd1,
    SLOT_RUNNING  = 2'd2,
    SLOT_DYING    = 2'd3
  } slot_state_e;

  typedef struct packed {
    req_type_e             req_type;
    logic [HANDLE_W-1:0]   handle;
    logic [HANDLE_W-1:0]   parent_handle;
    logic                  check_perm;
    logic [CPU_ID_W-1:0]   cpu;
  } req_t;

  typedef struct packed {
    status_e               status;
    logic [HANDLE_W-1:0]   handle_out;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  slot_valid;
    logic                  marked_dying;
  } rsp_t;

  // Write enables of the slot memory arrays.
  typedef struct packed {
    logic handle;
    logic state;
    logic parent;
    logic run_cnt;
    logic next;
  } mem_wen_t;

endpackage

>>> rtl/ghst_slot_mem.sv
// ----------------------------------------------------------------------------
// ghst_slot_mem: per-slot storage of the slot table
// Handle, state, parent, run count and free-list link arrays, one shared write
// address and one shared read address, read data registered.
// ----------------------------------------------------------------------------
module ghst_slot_mem #(
  parameter int unsigned SLOTS = ghst_pkg::SLOTS_DEF,
  localparam int unsigned IdxW = $clog2(SLOTS)
) (
  input  logic                               clk_i,
  input  logic [IdxW-1:0]                    rd_addr_i,
  input  logic [IdxW-1:0]                    wr_addr_i,
  input  ghst_pkg::mem_wen_t                 wen_i,
  input  logic [ghst_pkg::HANDLE_W-1:0]      wr_handle_i,
  input  ghst_pkg::slot_state_e              wr_state_i,
  input  logic [ghst_pkg::HANDLE_W-1:0]      wr_parent_i,
  input  logic [ghst_pkg::RUN_CNT_W-1:0]     wr_run_i,
  input  logic [IdxW:0]                      wr_next_i,
  output logic [ghst_pkg::HANDLE_W-1:0]      rd_handle_o,
  output ghst_pkg::slot_state_e              rd_state_o,
  output logic [ghst_pkg::HANDLE_W-1:0]      rd_parent_o,
  output logic [ghst_pkg::RUN_CNT_W-1:0]     rd_run_o,
  output logic [IdxW:0]                      rd_next_o
);

  logic [ghst_pkg::HANDLE_W-1:0]  handle_mem [SLOTS];
  ghst_pkg::slot_state_e          state_mem  [SLOTS];
  logic [ghst_pkg::HANDLE_W-1:0]  parent_mem [SLOTS];
  logic [ghst_pkg::RUN_CNT_W-1:0] run_mem    [SLOTS];
  logic [IdxW:0]                  next_mem   [SLOTS];

  always_ff @(posedge clk_i) begin
    if (wen_i.handle) begin
      handle_mem[wr_addr_i] <= wr_handle_i;
    end
    rd_handle_o <= handle_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wen_i.state) begin
      state_mem[wr_addr_i] <= wr_state_i;
    end
    rd_state_o <= state_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wen_i.parent) begin
      parent_mem[wr_addr_i] <= wr_parent_i;
    end
    rd_parent_o <= parent_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wen_i.run_cnt) begin
      run_mem[wr_addr_i] <= wr_run_i;
    end
    rd_run_o <= run_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wen_i.next) begin
      next_mem[wr_addr_i] <= wr_next_i;
    end
    rd_next_o <= next_mem[rd_addr_i];
  end

endmodule

>>> rtl/generation_handle_slot_table_unit.sv
// ----------------------------------------------------------------------------
// generation_handle_slot_table_unit: slot allocator with generation handles
// Free-list slot table serving alloc, lookup, destroy and run requests.
// ----------------------------------------------------------------------------
// A request word is taken on req_i at a rising edge where start is high and
// busy is low. Unless it is answered up front, busy then stays high until the
// response word appears on rsp_o, marked by done_o for exactly one cycle;
// done_o and a low busy coincide, so the next request can be taken in that
// same cycle. The receiver cannot stall. The states that a request visits are:
//   none when answered up front (bad cpu, bad handle 0 or index, empty list)
//   S_A_RD, S_A_WR for alloc; S_T_RD, S_T_CHK for a handle rejected once read
//   S_T_RD, S_T_CHK, S_EXEC for lookup and destroy, S_C_CHK before S_EXEC
//     with the parent check; S_T_RD, S_T_CHK, S_C_CHK if that check fails
//   the lookup states, then S_R_TGT, for run
// done_o is registered and follows the last of these states. One request is
// in flight at a time; the state sequence is set by the single read port of
// the slot memory, whose data is registered. After reset the block sweeps
// every slot of the slot memory (1024 by default), building the free list in
// slot order; busy is high during the sweep and no request is taken.
// ----------------------------------------------------------------------------
module generation_handle_slot_table_unit #(
  parameter int unsigned SLOTS     = ghst_pkg::SLOTS_DEF,
  parameter int unsigned CPUS      = ghst_pkg::CPUS_DEF,
  parameter int unsigned GEN_SHIFT = ghst_pkg::GEN_SHIFT_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ghst_pkg::req_t  req_i,
  output logic            done_o,
  output ghst_pkg::rsp_t  rsp_o
);

  localparam int unsigned IdxW     = $clog2(SLOTS);
  localparam int unsigned HeadW    = IdxW + 1;
  localparam int unsigned CpuW     = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int unsigned HandleW  = ghst_pkg::HANDLE_W;
  localparam int unsigned SlotIdxW = ghst_pkg::SLOT_IDX_W;
  localparam int unsigned RunW     = ghst_pkg::RUN_CNT_W;

  localparam logic [HandleW-1:0] GenInc   = HandleW'(1) << GEN_SHIFT;
  localparam logic [HandleW-1:0] IdxMask  = HandleW'(SLOTS - 1);
  localparam logic [HeadW-1:0]   SlotsEnd = HeadW'(SLOTS);
  localparam logic [IdxW-1:0]    LastIdx  = IdxW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_WR,
    S_T_RD,
    S_T_CHK,
    S_C_CHK,
    S_EXEC,
    S_R_TGT
  } state_e;

  state_e                state_q, state_d;
  ghst_pkg::req_t        req_q, req_d;
  logic [IdxW-1:0]       s_q, s_d;
  logic [HeadW-1:0]      cur_q, cur_d;
  logic [CpuW-1:0]       cpu_q, cpu_d;
  logic                  from_cur_q, from_cur_d;
  logic [HandleW-1:0]    tgt_handle_q, tgt_handle_d;
  ghst_pkg::slot_state_e tgt_state_q, tgt_state_d;
  logic [HandleW-1:0]    tgt_parent_q, tgt_parent_d;
  logic [RunW-1:0]       tgt_run_q, tgt_run_d;
  logic [HeadW-1:0]      head_q, head_d;
  logic [IdxW-1:0]       clr_q, clr_d;
  logic                  done_q, done_d;
  ghst_pkg::rsp_t        rsp_q, rsp_d;
  logic [HeadW-1:0]      current_q [CPUS];

  logic                  cur_we;
  logic [HeadW-1:0]      cur_wval;

  // Slot memory port signals.
  logic [IdxW-1:0]       rd_addr;
  logic [IdxW-1:0]       wr_addr;
  ghst_pkg::mem_wen_t    wen;
  logic [HandleW-1:0]    wr_handle;
  ghst_pkg::slot_state_e wr_state;
  logic [HandleW-1:0]    wr_parent;
  logic [RunW-1:0]       wr_run;
  logic [HeadW-1:0]      wr_next;
  logic [HandleW-1:0]    rd_handle;
  ghst_pkg::slot_state_e rd_state;
  logic [HandleW-1:0]    rd_parent;
  logic [RunW-1:0]       rd_run;
  logic [HeadW-1:0]      rd_next;

  // Request decode helpers.
  logic [CpuW-1:0]       in_cpu;
  logic                  in_cpu_ok;
  logic [HeadW-1:0]      in_cur;
  logic [HandleW-1:0]    in_hidx;
  logic [HandleW-1:0]    gen_sum;
  logic [HandleW-1:0]    gen;
  logic [HandleW-1:0]    new_handle;
  logic                  cur_none;
  logic                  cur_is_tgt;

  function automatic ghst_pkg::rsp_t make_rsp(ghst_pkg::status_e st,
                                              logic [HandleW-1:0] h,
                                              logic [IdxW-1:0] idx,
                                              logic valid,
                                              logic dying);
    ghst_pkg::rsp_t r;
    r.status       = st;
    r.handle_out   = h;
    r.slot_index   = SlotIdxW'({{SlotIdxW{1'b0}}, idx});
    r.slot_valid   = valid;
    r.marked_dying = dying;
    return r;
  endfunction

  ghst_slot_mem #(
    .SLOTS(SLOTS)
  ) u_slot_mem (
    .clk_i      (clk_i),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .wen_i      (wen),
    .wr_handle_i(wr_handle),
    .wr_state_i (wr_state),
    .wr_parent_i(wr_parent),
    .wr_run_i   (wr_run),
    .wr_next_i  (wr_next),
    .rd_handle_o(rd_handle),
    .rd_state_o (rd_state),
    .rd_parent_o(rd_parent),
    .rd_run_o   (rd_run),
    .rd_next_o  (rd_next)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign in_cpu     = CpuW'({{CpuW{1'b0}}, req_i.cpu});
  assign in_cpu_ok  = 32'(req_i.cpu) < 32'(CPUS);
  assign in_cur     = current_q[in_cpu];
  assign in_hidx    = req_i.handle & IdxMask;

  assign cur_none   = (cur_q >= SlotsEnd);
  assign cur_is_tgt = (cur_q == {1'b0, s_q});

  // The next generation keeps only the bits above the slot index.
  assign gen_sum    = rd_handle + GenInc;
  assign gen        = gen_sum & ~IdxMask;
  assign new_handle = ((gen == '0) ? GenInc : gen) | HandleW'(s_q);

  // The check states read the current slot: its handle for the parent check
  // and its state for the run request.
  assign rd_addr = (state_q == S_T_CHK || state_q == S_C_CHK) ? cur_q[IdxW-1:0] : s_q;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    s_d          = s_q;
    cur_d        = cur_q;
    cpu_d        = cpu_q;
    from_cur_d   = from_cur_q;
    tgt_handle_d = tgt_handle_q;
    tgt_state_d  = tgt_state_q;
    tgt_parent_d = tgt_parent_q;
    tgt_run_d    = tgt_run_q;
    head_d       = head_q;
    clr_d        = clr_q;
    done_d       = 1'b0;
    rsp_d        = rsp_q;
    cur_we       = 1'b0;
    cur_wval     = {1'b0, s_q};
    wen          = '0;
    wr_addr      = s_q;
    wr_handle    = new_handle;
    wr_state     = ghst_pkg::SLOT_FREE;
    wr_parent    = req_q.parent_handle;
    wr_run       = '0;
    wr_next      = head_q;

    unique case (state_q)
      S_CLEAR: begin
        wr_addr     = clr_q;
        wen.handle  = 1'b1;
        wen.state   = 1'b1;
        wen.next    = 1'b1;
        wr_handle   = '0;
        wr_state    = ghst_pkg::SLOT_FREE;
        wr_next     = {1'b0, clr_q} + HeadW'(1);
        clr_d       = clr_q + IdxW'(1);
        if (clr_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          req_d      = req_i;
          cpu_d      = in_cpu;
          cur_d      = in_cur;
          from_cur_d = 1'b0;
          if (req_i.req_type == ghst_pkg::REQ_ALLOC) begin
            if (head_q >= SlotsEnd) begin
              done_d = 1'b1;
              rsp_d  = make_rsp(ghst_pkg::STATUS_NO_FREE, '0, '0, 1'b0, 1'b0);
            end else begin
              s_d     = head_q[IdxW-1:0];
              state_d = S_A_RD;
            end
          end else if (!in_cpu_ok) begin
            done_d = 1'b1;
            rsp_d  = make_rsp(ghst_pkg::STATUS_BAD_HANDLE, '0, '0, 1'b0, 1'b0);
          end else if (req_i.handle == '0) begin
            // Handle 0 names the cpu's current slot, with no further check.
            if (in_cur >= SlotsEnd) begin
              done_d = 1'b1;
              if (req_i.req_type == ghst_pkg::REQ_LOOKUP) begin
                rsp_d = make_rsp(ghst_pkg::STATUS_OK, '0, '0, 1'b0, 1'b0);
              end else begin
                rsp_d = make_rsp(ghst_pkg::STATUS_BAD_HANDLE, '0, '0, 1'b0, 1'b0);
              end
            end else begin
              s_d        = in_cur[IdxW-1:0];
              from_cur_d = 1'b1;
              state_d    = S_T_RD;
            end
          end else if (in_hidx >= HandleW'(SLOTS)) begin
            done_d = 1'b1;
            rsp_d  = make_rsp(ghst_pkg::STATUS_BAD_HANDLE, '0, '0, 1'b0, 1'b0);
          end else begin
            s_d     = IdxW'(in_hidx);
            state_d = S_T_RD;
          end
        end
      end

      S_A_RD: begin
        state_d = S_A_WR;
      end

      S_A_WR: begin
        wen.handle  = 1'b1;
        wen.parent  = 1'b1;
        wen.state   = 1'b1;
        wen.run_cnt = 1'b1;
        wr_state    = ghst_pkg::SLOT_RUNNABLE;
        wr_run      = '0;
        head_d      = rd_next;
        done_d      = 1'b1;
        rsp_d       = make_rsp(ghst_pkg::STATUS_OK, new_handle, s_q, 1'b1, 1'b0);
        state_d     = S_IDLE;
      end

      S_T_RD: begin
        state_d = S_T_CHK;
      end

      S_T_CHK: begin
        tgt_handle_d = rd_handle;
        tgt_state_d  = rd_state;
        tgt_parent_d = rd_parent;
        tgt_run_d    = rd_run;
        if (from_cur_q) begin
          state_d = S_EXEC;
        end else if (rd_state == ghst_pkg::SLOT_FREE || rd_handle != req_q.handle
                     || (req_q.check_perm && cur_none)) begin
          done_d  = 1'b1;
          rsp_d   = make_rsp(ghst_pkg::STATUS_BAD_HANDLE, '0, '0, 1'b0, 1'b0);
          state_d = S_IDLE;
        end else if (req_q.check_perm && !cur_is_tgt) begin
          state_d = S_C_CHK;
        end else begin
          state_d = S_EXEC;
        end
      end

      S_C_CHK: begin
        // The target must be a child of the current slot.
        if (tgt_parent_q != rd_handle) begin
          done_d  = 1'b1;
          rsp_d   = make_rsp(ghst_pkg::STATUS_BAD_HANDLE, '0, '0, 1'b0, 1'b0);
          state_d = S_IDLE;
        end else begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_IDLE;
        unique case (req_q.req_type)
          ghst_pkg::REQ_LOOKUP: begin
            done_d = 1'b1;
            rsp_d  = make_rsp(ghst_pkg::STATUS_OK, tgt_handle_q, s_q, 1'b1, 1'b0);
          end
          ghst_pkg::REQ_DESTROY: begin
            wen.state = 1'b1;
            done_d    = 1'b1;
            if (tgt_state_q == ghst_pkg::SLOT_RUNNING && !cur_is_tgt) begin
              // Running elsewhere: only mark it, the owner frees it later.
              wr_state = ghst_pkg::SLOT_DYING;
              rsp_d    = make_rsp(ghst_pkg::STATUS_OK, tgt_handle_q, s_q, 1'b1, 1'b1);
            end else begin
              wr_state = ghst_pkg::SLOT_FREE;
              wen.next = 1'b1;
              wr_next  = head_q;
              head_d   = {1'b0, s_q};
              if (cur_is_tgt) begin
                cur_we   = 1'b1;
                cur_wval = '1;
              end
              rsp_d = make_rsp(ghst_pkg::STATUS_OK, tgt_handle_q, s_q, 1'b1, 1'b0);
            end
          end
          ghst_pkg::REQ_RUN: begin
            // rd_state holds the state of the cpu's current slot here.
            wr_addr = cur_q[IdxW-1:0];
            if (!cur_none && !cur_is_tgt && rd_state == ghst_pkg::SLOT_RUNNING) begin
              wen.state = 1'b1;
              wr_state  = ghst_pkg::SLOT_RUNNABLE;
            end
            state_d = S_R_TGT;
          end
          default: begin
            done_d = 1'b1;
            rsp_d  = make_rsp(ghst_pkg::STATUS_BAD_HANDLE, '0, '0, 1'b0, 1'b0);
          end
        endcase
      end

      S_R_TGT: begin
        wen.state   = 1'b1;
        wen.run_cnt = 1'b1;
        wr_state    = ghst_pkg::SLOT_RUNNING;
        wr_run      = tgt_run_q + RunW'(1);
        cur_we      = 1'b1;
        cur_wval    = {1'b0, s_q};
        done_d      = 1'b1;
        rsp_d       = make_rsp(ghst_pkg::STATUS_OK, tgt_handle_q, s_q, 1'b1, 1'b0);
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      req_q        <= '0;
      s_q          <= '0;
      cur_q        <= '1;
      cpu_q        <= '0;
      from_cur_q   <= 1'b0;
      tgt_handle_q <= '0;
      tgt_state_q  <= ghst_pkg::SLOT_FREE;
      tgt_parent_q <= '0;
      tgt_run_q    <= '0;
      head_q       <= '0;
      clr_q        <= '0;
      done_q       <= 1'b0;
      rsp_q        <= '0;
      for (int i = 0; i < CPUS; i++) begin
        current_q[i] <= '1;
      end
    end else begin
      state_q      <= state_d;
      req_q        <= req_d;
      s_q          <= s_d;
      cur_q        <= cur_d;
      cpu_q        <= cpu_d;
      from_cur_q   <= from_cur_d;
      tgt_handle_q <= tgt_handle_d;
      tgt_state_q  <= tgt_state_d;
      tgt_parent_q <= tgt_parent_d;
      tgt_run_q    <= tgt_run_d;
      head_q       <= head_d;
      clr_q        <= clr_d;
      done_q       <= done_d;
      rsp_q        <= rsp_d;
      if (cur_we) begin
        current_q[cpu_q] <= cur_wval;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("response word shown while the sequencer is still busy");

  a_no_free_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ghst_pkg::STATUS_NO_FREE) |-> (head_q >= SlotsEnd))
    else $error("no-free status reported while the free list holds a slot");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ghst_pkg::STATUS_OK)
      |-> (rsp_o.handle_out == '0 && !rsp_o.slot_valid && !rsp_o.marked_dying))
    else $error("failed request carries a handle or slot");

  a_valid_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.slot_valid) |-> (rsp_o.handle_out != '0))
    else $error("live slot answered with a zero handle");

  a_dying_destroy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.marked_dying)
      |-> (rsp_o.slot_valid && req_q.req_type == ghst_pkg::REQ_DESTROY))
    else $error("dying mark on a response that is not a deferred destroy");
`endif

endmodule

>>> tb/sv/tb_generation_handle_slot_table_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_generation_handle_slot_table_unit: self-checking bench for the slot table
// Drives a short directed table of requests, then several random phases. One
// phase fills the table until the free list is empty. Rows marked typed check
// against their own word, the rest against a behavioral copy of the slot table.
// ----------------------------------------------------------------------------
module tb_generation_handle_slot_table_unit;

  localparam int unsigned SLOTS = ghst_pkg::SLOTS_DEF;
  localparam int unsigned CPUS  = ghst_pkg::CPUS_DEF;
  localparam int unsigned HW    = ghst_pkg::HANDLE_W;
  localparam logic [10:0] NO_SLOT = '1;
  localparam logic [HW-1:0] GEN_STEP = HW'(1) << ghst_pkg::GEN_SHIFT_DEF;
  localparam logic [HW-1:0] IDX_MASK = HW'(SLOTS - 1);
  localparam int unsigned N_DIRECTED = 25;

  typedef struct packed {
    ghst_pkg::req_t req;
    bit             typed;
    ghst_pkg::rsp_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  ghst_pkg::req_t req_i = '0;
  logic done_o;
  ghst_pkg::rsp_t rsp_o;

  generation_handle_slot_table_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the slot table.
  logic [HW-1:0]                  tbl_handle [SLOTS];
  ghst_pkg::slot_state_e          tbl_state  [SLOTS];
  logic [HW-1:0]                  tbl_parent [SLOTS];
  logic [ghst_pkg::RUN_CNT_W-1:0] tbl_runs   [SLOTS];
  logic [10:0]                    tbl_next   [SLOTS];
  logic [10:0]                    tbl_head;
  logic [10:0]                    tbl_cur    [CPUS];
  int                             hi_water;

  ghst_pkg::rsp_t pending_rsp [$];
  int   mismatches = 0;
  int   burst_left = 0;

  function automatic void clear_slot_table();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_handle[i] = '0;
      tbl_state[i]  = ghst_pkg::SLOT_FREE;
      tbl_parent[i] = '0;
      tbl_runs[i]   = '0;
      tbl_next[i]   = 11'(i + 1);
    end
    tbl_head = '0;
    for (int i = 0; i < CPUS; i++) tbl_cur[i] = NO_SLOT;
    hi_water = 0;
  endfunction

  // Handle 0 stands for the cpu's current slot and is taken without checks.
  function automatic ghst_pkg::status_e resolve_slot(input ghst_pkg::req_t r,
                                                     output logic [10:0] idx);
    logic [10:0] cur;
    logic [9:0]  s;
    cur = tbl_cur[r.cpu];
    idx = NO_SLOT;
    if (r.handle == '0) begin
      idx = cur;
      return ghst_pkg::STATUS_OK;
    end
    s = r.handle[9:0];
    if (tbl_state[s] == ghst_pkg::SLOT_FREE || tbl_handle[s] != r.handle)
      return ghst_pkg::STATUS_BAD_HANDLE;
    if (r.check_perm) begin
      if (cur >= SLOTS) return ghst_pkg::STATUS_BAD_HANDLE;
      if ({1'b0, s} != cur && tbl_parent[s] != tbl_handle[cur[9:0]])
        return ghst_pkg::STATUS_BAD_HANDLE;
    end
    idx = {1'b0, s};
    return ghst_pkg::STATUS_OK;
  endfunction

  function automatic ghst_pkg::rsp_t serve_request(input ghst_pkg::req_t r);
    ghst_pkg::rsp_t    o;
    logic [10:0]       idx;
    logic [10:0]       cur;
    logic [9:0]        s;
    logic [HW-1:0]     gen;
    ghst_pkg::status_e st;
    o = '0;
    o.status = ghst_pkg::STATUS_OK;
    if (r.req_type == ghst_pkg::REQ_ALLOC) begin
      if (tbl_head >= SLOTS) begin
        o.status = ghst_pkg::STATUS_NO_FREE;
        return o;
      end
      s = tbl_head[9:0];
      gen = (tbl_handle[s] + GEN_STEP) & ~IDX_MASK;
      if (gen == '0) gen = GEN_STEP;
      tbl_handle[s] = gen | HW'(s);
      tbl_parent[s] = r.parent_handle;
      tbl_state[s]  = ghst_pkg::SLOT_RUNNABLE;
      tbl_runs[s]   = '0;
      tbl_head      = tbl_next[s];
      if (int'(s) > hi_water) hi_water = int'(s);
      o.handle_out = tbl_handle[s];
      o.slot_index = s;
      o.slot_valid = 1'b1;
      return o;
    end
    st = resolve_slot(r, idx);
    if (st != ghst_pkg::STATUS_OK || (idx >= SLOTS && r.req_type != ghst_pkg::REQ_LOOKUP)) begin
      o.status = ghst_pkg::STATUS_BAD_HANDLE;
      return o;
    end
    if (idx >= SLOTS) return o;
    cur = tbl_cur[r.cpu];
    s = idx[9:0];
    o.handle_out = tbl_handle[s];
    o.slot_index = s;
    o.slot_valid = 1'b1;
    if (r.req_type == ghst_pkg::REQ_DESTROY) begin
      // A slot running elsewhere is only marked; the other cpu frees it later.
      if (tbl_state[s] == ghst_pkg::SLOT_RUNNING && cur != idx) begin
        tbl_state[s] = ghst_pkg::SLOT_DYING;
        o.marked_dying = 1'b1;
        return o;
      end
      tbl_state[s] = ghst_pkg::SLOT_FREE;
      tbl_next[s]  = tbl_head;
      tbl_head     = idx;
      if (cur == idx) tbl_cur[r.cpu] = NO_SLOT;
    end else if (r.req_type == ghst_pkg::REQ_RUN) begin
      if (cur < SLOTS && tbl_state[cur[9:0]] == ghst_pkg::SLOT_RUNNING)
        tbl_state[cur[9:0]] = ghst_pkg::SLOT_RUNNABLE;
      tbl_cur[r.cpu] = idx;
      tbl_state[s]   = ghst_pkg::SLOT_RUNNING;
      tbl_runs[s]    = tbl_runs[s] + ghst_pkg::RUN_CNT_W'(1);
    end
    return o;
  endfunction

  // Mostly well-formed requests aimed at live slots; one in ten is pure noise.
  function automatic ghst_pkg::req_t random_request(input int w_alloc, input int w_lookup,
                                                    input int w_destroy);
    ghst_pkg::req_t r;
    int             pick;
    int             tries;
    logic [9:0]     s;
    logic [10:0]    cur;
    r.req_type      = ghst_pkg::REQ_LOOKUP;
    r.handle        = HW'($urandom);
    r.parent_handle = HW'($urandom);
    r.check_perm    = ($urandom_range(0, 2) == 0);
    r.cpu           = ghst_pkg::CPU_ID_W'($urandom_range(0, CPUS - 1));
    if ($urandom_range(0, 9) == 0) begin
      r.req_type   = ghst_pkg::req_type_e'($urandom_range(0, 3));
      r.check_perm = 1'($urandom_range(0, 1));
      return r;
    end
    pick = $urandom_range(0, 99);
    if (pick < w_alloc) r.req_type = ghst_pkg::REQ_ALLOC;
    else if (pick < w_alloc + w_lookup) r.req_type = ghst_pkg::REQ_LOOKUP;
    else if (pick < w_alloc + w_lookup + w_destroy) r.req_type = ghst_pkg::REQ_DESTROY;
    else r.req_type = ghst_pkg::REQ_RUN;
    cur = tbl_cur[r.cpu];
    pick = $urandom_range(0, 9);
    if (cur < SLOTS && pick < 6) r.parent_handle = tbl_handle[cur[9:0]];
    else if (pick < 8) r.parent_handle = tbl_handle[$urandom_range(0, hi_water)];
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      r.handle = '0;
    end else begin
      s = 10'($urandom_range(0, hi_water));
      for (tries = 0; tries < 16; tries++) begin
        if (tbl_state[s] != ghst_pkg::SLOT_FREE && (!r.check_perm || cur >= SLOTS ||
            s == cur[9:0] || tbl_parent[s] == tbl_handle[cur[9:0]]))
          break;
        s = 10'($urandom_range(0, hi_water));
      end
      r.handle = tbl_handle[s];
      if (r.handle == '0 || pick == 19)
        r.handle = ((tbl_handle[s] + GEN_STEP) & ~IDX_MASK) | HW'(s);
      else if (pick == 18)
        r.handle[$urandom_range(0, HW - 1)] ^= 1'b1;
    end
    return r;
  endfunction

  function automatic dir_row_t row(ghst_pkg::req_type_e t, logic [HW-1:0] h,
                                   logic [HW-1:0] p, bit perm, int cpu,
                                   bit typed = 1'b0,
                                   ghst_pkg::status_e st = ghst_pkg::STATUS_OK,
                                   logic [HW-1:0] ho = '0, int idx = 0,
                                   bit valid = 1'b0, bit dying = 1'b0);
    dir_row_t d;
    d.req.req_type        = t;
    d.req.handle          = h;
    d.req.parent_handle   = p;
    d.req.check_perm      = perm;
    d.req.cpu             = ghst_pkg::CPU_ID_W'(cpu);
    d.typed               = typed;
    d.want.status         = st;
    d.want.handle_out     = ho;
    d.want.slot_index     = ghst_pkg::SLOT_IDX_W'(idx);
    d.want.slot_valid     = valid;
    d.want.marked_dying   = dying;
    return d;
  endfunction

  // Presents one request word and holds it until the block takes it.
  task automatic send_request(input ghst_pkg::req_t r, input bit typed,
                              input ghst_pkg::rsp_t want);
    ghst_pkg::rsp_t predicted;
    int             gap;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = serve_request(r);
    pending_rsp.push_back(typed ? want : predicted);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 24);
    end else begin
      burst_left--;
    end
  endtask

  function automatic string rsp_text(input ghst_pkg::rsp_t r);
    return $sformatf("st %0d h %h idx %0d v %b d %b", r.status, r.handle_out,
                     r.slot_index, r.slot_valid, r.marked_dying);
  endfunction

  task automatic note_mismatch(input string what, input ghst_pkg::rsp_t want,
                               input ghst_pkg::rsp_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected %s, got %s", $time, what, rsp_text(want), rsp_text(got));
  endtask

  always @(posedge clk_i) begin : check_rsp
    ghst_pkg::rsp_t want;
    if (done_o === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        note_mismatch("response word with nothing pending", '0, rsp_o);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.status !== want.status || rsp_o.handle_out !== want.handle_out ||
            rsp_o.slot_index !== want.slot_index || rsp_o.slot_valid !== want.slot_valid ||
            rsp_o.marked_dying !== want.marked_dying)
          note_mismatch("response word differs", want, rsp_o);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    dir_row_t       dir_rows [N_DIRECTED];
    ghst_pkg::req_t r;
    int             n;
    int             waited;
    clear_slot_table();
    dir_rows = '{
      row(ghst_pkg::REQ_LOOKUP,  0, 0, 0, 0, 1, ghst_pkg::STATUS_OK),
      row(ghst_pkg::REQ_DESTROY, 0, 0, 0, 0, 1, ghst_pkg::STATUS_BAD_HANDLE),
      row(ghst_pkg::REQ_RUN,     0, 0, 0, 1, 1, ghst_pkg::STATUS_BAD_HANDLE),
      row(ghst_pkg::REQ_LOOKUP,  31'h7FFF_FFFF, 0, 0, 2, 1, ghst_pkg::STATUS_BAD_HANDLE),
      row(ghst_pkg::REQ_ALLOC,   0, 0, 0, 0, 1, ghst_pkg::STATUS_OK, 31'h1000, 0, 1),
      row(ghst_pkg::REQ_ALLOC,   0, 31'h1000, 0, 3, 1, ghst_pkg::STATUS_OK,
          31'h1001, 1, 1),
      row(ghst_pkg::REQ_ALLOC,   31'h7FFF_FFFF, 31'h7FFF_FFFF, 1, 7, 1, ghst_pkg::STATUS_OK,
          31'h1002, 2, 1),
      // Permission check while the cpu has no current slot.
      row(ghst_pkg::REQ_LOOKUP,  31'h1001, 0, 1, 0, 1, ghst_pkg::STATUS_BAD_HANDLE),
      row(ghst_pkg::REQ_RUN,     31'h1000, 0, 0, 0, 1, ghst_pkg::STATUS_OK, 31'h1000, 0, 1),
      row(ghst_pkg::REQ_LOOKUP,  31'h1001, 0, 1, 0, 1, ghst_pkg::STATUS_OK, 31'h1001, 1, 1),
      row(ghst_pkg::REQ_LOOKUP,  31'h1002, 0, 1, 0, 1, ghst_pkg::STATUS_BAD_HANDLE),
      row(ghst_pkg::REQ_LOOKUP,  0, 0, 1, 0, 1, ghst_pkg::STATUS_OK, 31'h1000, 0, 1),
      row(ghst_pkg::REQ_RUN,     31'h1001, 0, 0, 7, 1, ghst_pkg::STATUS_OK, 31'h1001, 1, 1),
      // Slot 1 runs on cpu 7, so the destroy from cpu 0 is deferred.
      row(ghst_pkg::REQ_DESTROY, 31'h1001, 0, 0, 0, 1, ghst_pkg::STATUS_OK,
          31'h1001, 1, 1, 1),
      row(ghst_pkg::REQ_RUN,     31'h1001, 0, 0, 0, 1, ghst_pkg::STATUS_OK, 31'h1001, 1, 1),
      row(ghst_pkg::REQ_DESTROY, 31'h1001, 0, 0, 0, 1, ghst_pkg::STATUS_OK, 31'h1001, 1, 1),
      // Cpu 7 still names the freed slot.
      row(ghst_pkg::REQ_LOOKUP,  0, 0, 0, 7, 1, ghst_pkg::STATUS_OK, 31'h1001, 1, 1),
      row(ghst_pkg::REQ_LOOKUP,  31'h1001, 0, 0, 3, 1, ghst_pkg::STATUS_BAD_HANDLE),
      row(ghst_pkg::REQ_ALLOC,   0, 31'h1000, 0, 2, 1, ghst_pkg::STATUS_OK,
          31'h2001, 1, 1),
      row(ghst_pkg::REQ_LOOKUP,  31'h1001, 0, 0, 3, 1, ghst_pkg::STATUS_BAD_HANDLE),
      row(ghst_pkg::REQ_DESTROY, 0, 0, 0, 7, 1, ghst_pkg::STATUS_OK, 31'h2001, 1, 1),
      row(ghst_pkg::REQ_DESTROY, 0, 0, 0, 7, 1, ghst_pkg::STATUS_BAD_HANDLE),
      row(ghst_pkg::REQ_RUN,     31'h1002, 0, 1, 0, 1, ghst_pkg::STATUS_BAD_HANDLE),
      row(ghst_pkg::REQ_LOOKUP,  31'h7FFF_F000, 0, 0, 0, 1, ghst_pkg::STATUS_BAD_HANDLE),
      row(ghst_pkg::REQ_RUN,     31'h1002, 0, 0, 5)
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    // Growth: allocation-heavy mix.
    repeat (40) send_request(random_request(55, 20, 10), 1'b0, '0);

    // Fill with allocations until the free list runs dry, then try a few more.
    n = 0;
    while (tbl_head < SLOTS && n < 3000) begin
      r = random_request(100, 0, 0);
      r.req_type = ghst_pkg::REQ_ALLOC;
      send_request(r, 1'b0, '0);
      n++;
    end
    repeat (6) send_request(random_request(100, 0, 0), 1'b0, '0);

    // Churn on a nearly full table: destroy-heavy mix.
    repeat (60) send_request(random_request(20, 25, 35), 1'b0, '0);
    start <= 1'b0;

    waited = 0;
    while (pending_rsp.size() != 0 && waited < 200) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_rsp.size() != 0) begin
      $display("%0d response words never arrived", pending_rsp.size());
      mismatches += pending_rsp.size();
    end

    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
